// File: rtl/bsd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the bounded shift deque.
// No dependencies; imported by every module of the block.
package bsd_pkg;

	localparam int MAX_DEPTH = 16;
	localparam int DATA_WIDTH = 32;

	// fixed field widths of the channels
	localparam int VAL_W = 32;
	localparam int IDX_W = 8;
	localparam int CAP_W = 5;
	localparam int MODE_W = 3;

	localparam int CNT_W = $clog2(MAX_DEPTH + 1);
	localparam int SLOT_AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int CMP_W = ((CNT_W > IDX_W) ? CNT_W : IDX_W) + 1;
	localparam int CAP_RESET = (16 > MAX_DEPTH) ? MAX_DEPTH : 16;

	// index reduction: bits of the index consumed per cycle
	localparam int MOD_BITS = 2;
	localparam int MOD_STEPS = IDX_W / MOD_BITS;
	localparam int MOD_SW = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

	typedef enum logic [MODE_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_POP_FRONT  = 3'd1,
		OP_PUSH_BACK  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_WRITE_IDX  = 3'd4,
		OP_REMOVE     = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_TAKE_LOWER,
		CELL_TAKE_UPPER
	} cell_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MOD,
		ST_EXEC,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [IDX_W-1:0]  index;
		logic [VAL_W-1:0]  value;
	} req_t;

	typedef struct packed {
		logic [VAL_W-1:0] front_value;
		logic [VAL_W-1:0] back_value;
		logic [CAP_W-1:0] fill_count;
		logic             error;
	} rsp_t;

endpackage

// File: rtl/bsd_cell.sv
`timescale 1ns / 1ps
// One slot of the deque: holds an element, loads a new one or takes a neighbor's.
// Depends on bsd_pkg.
module bsd_cell (
	input  logic                           clk,
	input  bsd_pkg::cell_op_t              cmd,
	input  logic [bsd_pkg::DATA_WIDTH-1:0] load_data,
	input  logic [bsd_pkg::DATA_WIDTH-1:0] lower_data,
	input  logic [bsd_pkg::DATA_WIDTH-1:0] upper_data,
	output logic [bsd_pkg::DATA_WIDTH-1:0] slot
);
	import bsd_pkg::*;

	logic [DATA_WIDTH-1:0] slot_q;

	always_ff @(posedge clk) begin
		case (cmd)
			CELL_LOAD:       slot_q <= load_data;
			CELL_TAKE_LOWER: slot_q <= lower_data;
			CELL_TAKE_UPPER: slot_q <= upper_data;
			default:         slot_q <= slot_q;
		endcase
	end

	assign slot = slot_q;

endmodule

// File: rtl/bsd_mod.sv
`timescale 1ns / 1ps
// Index reduction modulo the capacity: restoring remainder, two index bits per cycle.
// Depends on bsd_pkg.
module bsd_mod (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [bsd_pkg::IDX_W-1:0] dividend,
	input  logic [bsd_pkg::CNT_W-1:0] divisor,
	output logic                      done,
	output logic [bsd_pkg::CNT_W-1:0] remainder
);
	import bsd_pkg::*;

	logic               busy_q;
	logic               done_q;
	logic [MOD_SW-1:0]  step_q;
	logic [IDX_W-1:0]   div_q;
	logic [CNT_W-1:0]   rem_q;
	logic [CNT_W-1:0]   rem_d;

	always_comb begin
		logic [CNT_W:0] t;
		t = {1'b0, rem_q};
		for (int k = 0; k < MOD_BITS; k++) begin
			t = {t[CNT_W-1:0], div_q[IDX_W-1-k]};
			if (t >= {1'b0, divisor}) begin
				t = t - {1'b0, divisor};
			end
		end
		rem_d = t[CNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == MOD_SW'(MOD_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			div_q <= div_q << MOD_BITS;
			rem_q <= rem_d;
		end
	end

	assign done = done_q;
	assign remainder = rem_q;

endmodule

// File: rtl/bounded_shift_deque_top.sv
`timescale 1ns / 1ps
// Bounded deque over a row of shifting slot cells, with sequencer and result register.
// Depends on bsd_pkg, bsd_cell and bsd_mod.
//
// Usage:
//   req channel (req_valid, req_stall, req): one operation per transaction,
//   push/pop at either end, write at index (mod capacity) or remove at index.
//   rsp channel (rsp_valid, rsp_stall, rsp): one result per operation with the
//   front and back elements, the count and an error flag.
//   cfg channel (cfg_valid, cfg_ready, cfg_data): capacity, taken only while
//   the deque is empty; 0 reads as 1, values above the depth as the depth.
// Timing: an operation is accepted, applied to all cells at once in the execute
//   state and its result is registered in the done state once the receiver does
//   not stall; no new operation is taken before that result is loaded. Write at
//   index first waits on the remainder unit, which reduces two index bits a cycle.
// Reset: count cleared, capacity back to 16; slot contents are not cleared.
// A stalled receiver holds the result register; the next operation is
//   accepted meanwhile but its result waits until the register is taken.
module bounded_shift_deque_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  bsd_pkg::req_t             req,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output bsd_pkg::rsp_t             rsp,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [bsd_pkg::CAP_W-1:0] cfg_data
);
	import bsd_pkg::*;

	state_t                state_q, state_d;
	req_t                  req_q;
	logic [CNT_W-1:0]      held_q, held_d;
	logic [CNT_W-1:0]      cap_q;
	logic                  err_q, err_d;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;

	logic                  accept;
	logic                  mod_start;
	logic                  mod_done;
	logic [CNT_W-1:0]      mod_rem;
	logic                  exec;
	logic                  rsp_load;

	logic [DATA_WIDTH-1:0] load_val;
	logic [DATA_WIDTH-1:0] slot_d [MAX_DEPTH];
	cell_op_t              cell_cmd [MAX_DEPTH];

	logic [CMP_W-1:0]      hq_w, cq_w, idx_w, rem_w, last_up;
	logic                  room, idx_ok;
	logic [SLOT_AW-1:0]    back_idx;

	assign accept = req_valid && !req_stall;
	assign cfg_ready = 1'b1;

	// sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (req.mode == OP_WRITE_IDX) ? ST_MOD : ST_EXEC;
				end
			end
			ST_MOD:  if (mod_done) state_d = ST_EXEC;
			ST_EXEC: state_d = ST_DONE;
			ST_DONE: if (rsp_load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_stall = (state_q != ST_IDLE);
		mod_start = accept && (req.mode == OP_WRITE_IDX);
		exec = (state_q == ST_EXEC);
		rsp_load = (state_q == ST_DONE) && (!rsp_valid_q || !rsp_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			held_q <= '0;
			cap_q <= CNT_W'(CAP_RESET);
			err_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (exec) begin
				held_q <= held_d;
				err_q <= err_d;
			end
			if (cfg_valid && cfg_ready && held_q == '0) begin
				if (cfg_data == '0) begin
					cap_q <= CNT_W'(1);
				end else if (CMP_W'(cfg_data) > CMP_W'(MAX_DEPTH)) begin
					cap_q <= CNT_W'(MAX_DEPTH);
				end else begin
					cap_q <= CNT_W'(cfg_data);
				end
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (rsp_load) begin
			rsp_q.front_value <= (held_q == '0) ? '0 : VAL_W'(slot_d[0]);
			rsp_q.back_value <= (held_q == '0) ? '0 : VAL_W'(slot_d[back_idx]);
			rsp_q.fill_count <= CAP_W'(held_q);
			rsp_q.error <= err_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	bsd_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (req.index),
		.divisor   (cap_q),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	// shared bounds for the per-cell decisions
	assign hq_w = CMP_W'(held_q);
	assign cq_w = CMP_W'(cap_q);
	assign idx_w = CMP_W'(req_q.index);
	assign rem_w = CMP_W'(mod_rem);
	assign room = hq_w < cq_w;
	assign idx_ok = idx_w < hq_w;
	assign last_up = room ? hq_w : (cq_w - 1'b1);
	assign back_idx = SLOT_AW'(held_q - 1'b1);
	assign load_val = DATA_WIDTH'(req_q.value);

	always_comb begin
		err_d = 1'b0;
		held_d = held_q;
		case (req_q.mode)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (room) held_d = held_q + 1'b1;
			end
			OP_POP_FRONT, OP_POP_BACK: begin
				if (held_q == '0) err_d = 1'b1;
				else held_d = held_q - 1'b1;
			end
			OP_REMOVE: begin
				if (!idx_ok) err_d = 1'b1;
				else held_d = held_q - 1'b1;
			end
			default: held_d = held_q;
		endcase
	end

	for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_cell
		logic [CMP_W-1:0]      pos, pos_p1;
		logic [DATA_WIDTH-1:0] lower, upper;

		assign pos = CMP_W'(i);
		assign pos_p1 = CMP_W'(i + 1);

		if (i == 0) begin : g_first
			assign lower = load_val;
		end else begin : g_lower
			assign lower = slot_d[i-1];
		end
		if (i == MAX_DEPTH - 1) begin : g_last
			assign upper = slot_d[i];
		end else begin : g_upper
			assign upper = slot_d[i+1];
		end

		always_comb begin
			cell_cmd[i] = CELL_HOLD;
			if (exec) begin
				case (req_q.mode)
					OP_PUSH_FRONT: begin
						if (pos == '0) cell_cmd[i] = CELL_LOAD;
						else if (pos <= last_up) cell_cmd[i] = CELL_TAKE_LOWER;
					end
					OP_POP_FRONT: begin
						if (pos_p1 < hq_w) cell_cmd[i] = CELL_TAKE_UPPER;
					end
					OP_PUSH_BACK: begin
						if (room) begin
							if (pos == hq_w) cell_cmd[i] = CELL_LOAD;
						end else if (pos_p1 < cq_w) begin
							cell_cmd[i] = CELL_TAKE_UPPER;
						end else if (pos_p1 == cq_w) begin
							cell_cmd[i] = CELL_LOAD;
						end
					end
					OP_WRITE_IDX: begin
						if (pos == rem_w) cell_cmd[i] = CELL_LOAD;
					end
					OP_REMOVE: begin
						if (idx_ok && pos >= idx_w && pos_p1 < hq_w) begin
							cell_cmd[i] = CELL_TAKE_UPPER;
						end
					end
					default: cell_cmd[i] = CELL_HOLD;
				endcase
			end
		end

		bsd_cell u_cell (
			.clk        (clk),
			.cmd        (cell_cmd[i]),
			.load_data  (load_val),
			.lower_data (lower),
			.upper_data (upper),
			.slot       (slot_d[i])
		);
	end

	a_held_le_cap: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= cap_q)
		else $error("fill count above capacity");

	a_held_only_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_EXEC) |=> $stable(held_q))
		else $error("fill count changed outside execute");

	a_err_only_refusal: assert property (@(posedge clk) disable iff (!arst_n)
		(exec && err_d) |-> (req_q.mode == OP_POP_FRONT || req_q.mode == OP_POP_BACK ||
			req_q.mode == OP_REMOVE))
		else $error("error raised by an operation that cannot fail");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (req_stall && !rsp_load))
		else $error("second transaction or early result after accept");

endmodule
